[rtl/dtemc_pkg.sv]
package dtemc_pkg;

  // field widths
  localparam int unsigned DRAW_W   = 32;
  localparam int unsigned N_W      = 21;
  localparam int unsigned STEP_W   = 16;
  localparam int unsigned SIG_W    = 52;
  localparam int unsigned RATIO_W  = 17;
  localparam int unsigned RATE_W   = 32;
  localparam int unsigned FRAC_W   = 16;

  // denominator Ne*R + n*(1-R) in Q.16 stays below 2^37
  localparam int unsigned DEN_W    = 37;

  // shared shift-add multiplier
  localparam int unsigned MCAND_W  = 53;
  localparam int unsigned MPLIER_W = 32;
  localparam int unsigned MPROD_W  = MCAND_W + MPLIER_W;

  // configuration port
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_NUM_STEPS      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TOTAL_TRAPS    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INITIAL_FILLED = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CAPTURE_RATIO  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DETRAP_RATE    = 3'd4;

  localparam logic [RATIO_W-1:0] RATIO_ONE = 17'd65536;
  localparam logic [SIG_W-1:0]   SIG_MAX   = {SIG_W{1'b1}};

  localparam int unsigned MAX_TRAPS_DEF = 1048576;
  localparam int unsigned MAX_STEPS_DEF = 65535;

  localparam int unsigned OUT_TDATA_W = 96;

endpackage

[rtl/dtemc_sermul.sv]
// Shift-add multiplier, one multiplier bit per cycle, LSB first.
// The low half of the product shifts into the multiplier register as its
// bits are consumed, so only an MW-bit adder sits between registers.
module dtemc_sermul #(
  parameter int unsigned MW = dtemc_pkg::MCAND_W,
  parameter int unsigned QW = dtemc_pkg::MPLIER_W
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [MW-1:0]    mcand_i,
  input  logic [QW-1:0]    mplier_i,
  output logic             done_o,
  output logic [MW+QW-1:0] prod_o
);

  localparam int unsigned CntW = $clog2(QW + 1);

  logic [CntW-1:0] cnt_q, cnt_d;
  logic [MW-1:0]   mcand_q, mcand_d;
  logic [MW-1:0]   acc_q, acc_d;
  logic [QW-1:0]   low_q, low_d;
  logic [MW:0]     sum;

  assign sum = {1'b0, acc_q} + (low_q[0] ? {1'b0, mcand_q} : {(MW+1){1'b0}});

  always_comb begin
    cnt_d   = cnt_q;
    mcand_d = mcand_q;
    acc_d   = acc_q;
    low_d   = low_q;
    if (start_i) begin
      cnt_d   = CntW'(QW);
      mcand_d = mcand_i;
      acc_d   = '0;
      low_d   = mplier_i;
    end else if (cnt_q != '0) begin
      cnt_d = cnt_q - 1'b1;
      acc_d = sum[MW:1];
      low_d = {sum[0], low_q[QW-1:1]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mcand_q <= mcand_d;
    acc_q   <= acc_d;
    low_q   <= low_d;
  end

  assign done_o = (cnt_q == '0);
  assign prod_o = {acc_q, low_q};

endmodule

[rtl/dtemc_serdiv.sv]
// Restoring divider, one quotient bit per cycle. The caller hands over the
// upper part of the dividend already reduced below the divisor, so the
// quotient fits QW bits.
module dtemc_serdiv #(
  parameter int unsigned QW = dtemc_pkg::SIG_W,
  parameter int unsigned DW = dtemc_pkg::DEN_W
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [DW-1:0] rem_init_i,
  input  logic [QW-1:0] low_i,
  input  logic [DW-1:0] divisor_i,
  output logic          done_o,
  output logic [QW-1:0] quo_o
);

  localparam int unsigned CntW = $clog2(QW + 1);

  logic [CntW-1:0] cnt_q, cnt_d;
  logic [DW-1:0]   rem_q, rem_d;
  logic [DW-1:0]   dvs_q, dvs_d;
  logic [QW-1:0]   sh_q, sh_d;
  logic [DW:0]     trial;
  logic [DW:0]     diff;
  logic            fits;

  assign trial = {rem_q, sh_q[QW-1]};
  assign diff  = trial - {1'b0, dvs_q};
  assign fits  = (trial >= {1'b0, dvs_q});

  always_comb begin
    cnt_d = cnt_q;
    rem_d = rem_q;
    dvs_d = dvs_q;
    sh_d  = sh_q;
    if (start_i) begin
      cnt_d = CntW'(QW);
      rem_d = rem_init_i;
      dvs_d = divisor_i;
      sh_d  = low_i;
    end else if (cnt_q != '0) begin
      cnt_d = cnt_q - 1'b1;
      rem_d = fits ? diff[DW-1:0] : trial[DW-1:0];
      sh_d  = {sh_q[QW-2:0], fits};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dvs_q <= dvs_d;
    sh_q  <= sh_d;
  end

  assign done_o = (cnt_q == '0);
  assign quo_o  = sh_q;

endmodule

[rtl/delocalized_trap_emptying_monte_carlo.sv]
// Monte Carlo trap emptying through a delocalized band. Each request on the
// input stream is one trial with a Q0.32 uniform draw, or a restart (tuser)
// that reloads the run from the registers. One item is worked on at a time.
// A trial that does not close a time step runs acceptance, the product and sum
// states that form the denominator, 32 steps of the bit-serial multiplier for
// the draw test and a decision. A trial that closes a step with traps left adds
// the signal: denominator again, two 32-step multiplier passes for A*n^2 and,
// unless the quotient saturates, 52 steps of the bit-serial divider. Restarts
// and trials after the run has ended stay in idle; an empty population is sent
// straight to output. The next request is taken while a result waits on output.
module delocalized_trap_emptying_monte_carlo #(
  parameter int unsigned MAX_TRAPS = dtemc_pkg::MAX_TRAPS_DEF,
  parameter int unsigned MAX_STEPS = dtemc_pkg::MAX_STEPS_DEF
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  logic [dtemc_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [dtemc_pkg::CFG_DATA_W-1:0]       cfg_data_i,
  input  logic                                   s_axis_tvalid,
  output logic                                   s_axis_tready,
  input  logic [dtemc_pkg::DRAW_W-1:0]           s_axis_tdata,  // random_draw
  input  logic [0:0]                             s_axis_tuser,  // restart
  output logic                                   m_axis_tvalid,
  input  logic                                   m_axis_tready,
  // step_index [15:0], signal_value [67:16], remaining_filled [88:68], zero fill
  output logic [dtemc_pkg::OUT_TDATA_W-1:0]      m_axis_tdata,
  output logic                                   m_axis_tlast
);

  localparam int unsigned NW    = dtemc_pkg::N_W;
  localparam int unsigned SW    = dtemc_pkg::STEP_W;
  localparam int unsigned GW    = dtemc_pkg::SIG_W;
  localparam int unsigned DW    = dtemc_pkg::DEN_W;
  localparam int unsigned RW    = dtemc_pkg::RATIO_W;
  localparam int unsigned PW    = NW + RW;
  localparam int unsigned UW    = dtemc_pkg::DRAW_W;
  localparam int unsigned MW    = dtemc_pkg::MCAND_W;
  localparam int unsigned QW    = dtemc_pkg::MPLIER_W;
  localparam int unsigned XW    = dtemc_pkg::MPROD_W;
  // A*n^2 width and the split of A*n^2*2^16 at the quotient limit
  localparam int unsigned AN2W  = dtemc_pkg::RATE_W + 2 * NW;
  localparam int unsigned HI_SH = GW - dtemc_pkg::FRAC_W;
  // draw test: u*D < n*2^48
  localparam int unsigned TST_SH = UW + dtemc_pkg::FRAC_W;
  localparam int unsigned PADW  = dtemc_pkg::OUT_TDATA_W - SW - GW - NW;

  localparam logic [31:0] MaxTrapsL = 32'(MAX_TRAPS);
  localparam logic [31:0] MaxStepsL = 32'(MAX_STEPS);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_PROD   = 3'd1;
  localparam logic [2:0] ST_SUM    = 3'd2;
  localparam logic [2:0] ST_MUL_U  = 3'd3;
  localparam logic [2:0] ST_MUL_AN = 3'd4;
  localparam logic [2:0] ST_MUL_PN = 3'd5;
  localparam logic [2:0] ST_DIV    = 3'd6;
  localparam logic [2:0] ST_EMIT   = 3'd7;

  // configuration
  logic [SW-1:0]                   num_steps_q;
  logic [NW-1:0]                   ne_q;
  logic [NW-1:0]                   init_q;
  logic [RW-1:0]                   ratio_q;
  logic [dtemc_pkg::RATE_W-1:0]    rate_q;

  // run state
  logic [2:0]    state_q, state_d;
  logic [NW-1:0] n_q, n_d;
  logic [NW-1:0] trial_q, trial_d;
  logic [SW-1:0] step_q, step_d;
  logic          done_q, done_d;
  logic          outmode_q, outmode_d;
  logic [UW-1:0] draw_q, draw_d;
  logic [PW-1:0] p1_q, p1_d;
  logic [PW-1:0] p2_q, p2_d;
  logic [DW-1:0] d_q, d_d;
  logic [GW-1:0] sig_q, sig_d;

  // output register
  logic          m_valid_q, m_valid_d;
  logic [SW-1:0] o_step_q, o_step_d;
  logic [GW-1:0] o_sig_q, o_sig_d;
  logic [NW-1:0] o_rem_q, o_rem_d;
  logic          o_last_q, o_last_d;

  logic          in_acc;
  logic [NW-1:0] cap_fill;
  logic [SW-1:0] step_lim;
  logic [RW-1:0] rc;
  logic [RW-1:0] rcomp;
  logic [PW-1:0] p1_full;
  logic [PW-1:0] p2_full;
  logic [DW-1:0] den_sum;
  logic          last_w;
  logic          hit;
  logic [NW-1:0] n_new;
  logic [NW-1:0] trial_new;

  logic          mul_start;
  logic [MW-1:0] mul_mcand;
  logic [QW-1:0] mul_mplier;
  logic          mul_done;
  logic [XW-1:0] mul_prod;
  logic          div_start;
  logic          div_done;
  logic [GW-1:0] div_quo;

  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign cfg_ready_o   = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_steps_q <= SW'(1);
      ne_q        <= NW'(1);
      init_q      <= '0;
      ratio_q     <= '0;
      rate_q      <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        dtemc_pkg::REG_NUM_STEPS:      num_steps_q <= cfg_data_i[SW-1:0];
        dtemc_pkg::REG_TOTAL_TRAPS:    ne_q        <= cfg_data_i[NW-1:0];
        dtemc_pkg::REG_INITIAL_FILLED: init_q      <= cfg_data_i[NW-1:0];
        dtemc_pkg::REG_CAPTURE_RATIO:  ratio_q     <= cfg_data_i[RW-1:0];
        dtemc_pkg::REG_DETRAP_RATE:    rate_q      <= cfg_data_i[dtemc_pkg::RATE_W-1:0];
        default: ;
      endcase
    end
  end

  assign cap_fill = (32'(init_q) > MaxTrapsL) ? MaxTrapsL[NW-1:0] : init_q;
  assign step_lim = (32'(num_steps_q) > MaxStepsL) ? MaxStepsL[SW-1:0] : num_steps_q;
  assign rc       = (ratio_q > dtemc_pkg::RATIO_ONE) ? dtemc_pkg::RATIO_ONE : ratio_q;
  assign rcomp    = dtemc_pkg::RATIO_ONE - rc;
  assign p1_full  = ne_q * rc;
  assign p2_full  = n_q * rcomp;
  assign den_sum  = DW'(p1_q + p2_q);
  assign last_w   = (n_q == '0) || (({1'b0, step_q} + 1'b1) >= {1'b0, step_lim});

  assign hit       = (mul_prod[TST_SH+NW-1:TST_SH] < n_q);
  assign n_new     = hit ? n_q - 1'b1 : n_q;
  assign trial_new = trial_q + 1'b1;

  always_comb begin
    state_d    = state_q;
    n_d        = n_q;
    trial_d    = trial_q;
    step_d     = step_q;
    done_d     = done_q;
    outmode_d  = outmode_q;
    draw_d     = draw_q;
    p1_d       = p1_q;
    p2_d       = p2_q;
    d_d        = d_q;
    sig_d      = sig_q;
    m_valid_d  = m_valid_q && !m_axis_tready;
    o_step_d   = o_step_q;
    o_sig_d    = o_sig_q;
    o_rem_d    = o_rem_q;
    o_last_d   = o_last_q;
    mul_start  = 1'b0;
    mul_mcand  = '0;
    mul_mplier = '0;
    div_start  = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (s_axis_tuser[0]) begin
            n_d     = cap_fill;
            trial_d = '0;
            step_d  = '0;
            done_d  = 1'b0;
          end else if (!done_q) begin
            if (step_q >= step_lim) begin
              done_d = 1'b1;
            end else if (n_q != '0) begin
              draw_d    = s_axis_tdata;
              outmode_d = 1'b0;
              state_d   = ST_PROD;
            end else begin
              // empty at step start: this request is the report
              sig_d   = '0;
              state_d = ST_EMIT;
            end
          end
        end
      end
      ST_PROD: begin
        p1_d    = p1_full;
        p2_d    = p2_full;
        state_d = ST_SUM;
      end
      ST_SUM: begin
        d_d       = den_sum;
        mul_start = 1'b1;
        if (outmode_q) begin
          mul_mcand  = MW'(rate_q);
          mul_mplier = QW'(n_q);
          state_d    = ST_MUL_AN;
        end else begin
          mul_mcand  = MW'(den_sum);
          mul_mplier = QW'(draw_q);
          state_d    = ST_MUL_U;
        end
      end
      ST_MUL_U: begin
        if (mul_done) begin
          n_d     = n_new;
          trial_d = trial_new;
          if (n_new != '0 && trial_new < n_new) begin
            state_d = ST_IDLE;
          end else if (n_new == '0) begin
            sig_d   = '0;
            state_d = ST_EMIT;
          end else begin
            outmode_d = 1'b1;
            state_d   = ST_PROD;
          end
        end
      end
      ST_MUL_AN: begin
        if (mul_done) begin
          mul_start  = 1'b1;
          mul_mcand  = mul_prod[MW-1:0];
          mul_mplier = QW'(n_q);
          state_d    = ST_MUL_PN;
        end
      end
      ST_MUL_PN: begin
        if (mul_done) begin
          // quotient would reach 2^52 (also covers a zero denominator)
          if (mul_prod[AN2W-1:HI_SH] >= {1'b0, d_q}) begin
            sig_d   = dtemc_pkg::SIG_MAX;
            state_d = ST_EMIT;
          end else begin
            div_start = 1'b1;
            state_d   = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        if (div_done) begin
          sig_d   = div_quo;
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!m_valid_q || m_axis_tready) begin
          m_valid_d = 1'b1;
          o_step_d  = step_q;
          o_sig_d   = sig_q;
          o_rem_d   = n_q;
          o_last_d  = last_w;
          step_d    = step_q + 1'b1;
          trial_d   = '0;
          done_d    = last_w;
          state_d   = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      n_q       <= '0;
      trial_q   <= '0;
      step_q    <= '0;
      done_q    <= 1'b0;
      outmode_q <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      n_q       <= n_d;
      trial_q   <= trial_d;
      step_q    <= step_d;
      done_q    <= done_d;
      outmode_q <= outmode_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    draw_q   <= draw_d;
    p1_q     <= p1_d;
    p2_q     <= p2_d;
    d_q      <= d_d;
    sig_q    <= sig_d;
    o_step_q <= o_step_d;
    o_sig_q  <= o_sig_d;
    o_rem_q  <= o_rem_d;
    o_last_q <= o_last_d;
  end

  dtemc_sermul #(
    .MW(MW),
    .QW(QW)
  ) u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .mcand_i (mul_mcand),
    .mplier_i(mul_mplier),
    .done_o  (mul_done),
    .prod_o  (mul_prod)
  );

  dtemc_serdiv #(
    .QW(GW),
    .DW(DW)
  ) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .rem_init_i(mul_prod[HI_SH+DW-1:HI_SH]),
    .low_i     ({mul_prod[HI_SH-1:0], {(GW-HI_SH){1'b0}}}),
    .divisor_i (d_q),
    .done_o    (div_done),
    .quo_o     (div_quo)
  );

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {{PADW{1'b0}}, o_rem_q, o_sig_q, o_step_q};
  assign m_axis_tlast  = o_last_q;

  a_units_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> (mul_done && div_done))
    else $error("arithmetic unit busy while waiting for a request");

  a_n_falls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_acc && s_axis_tuser[0]) |=> (n_q <= $past(n_q)))
    else $error("filled count rose without a restart");

  a_empty_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_valid_q && (o_rem_q == '0)) |-> o_last_q)
    else $error("empty population not flagged as end of run");

  a_busy_open: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |-> !done_q)
    else $error("trial in progress on a finished run");

endmodule
